[design/gpcms_pkg.sv]
// shared constants and types for the grid path count / max sum block
`default_nettype none
package gpcms_pkg;

   localparam int DEF_MAX_SIDE    = 128;
   localparam int CFG_W           = 8;
   localparam int COUNT_W         = 30;
   localparam int SUM_W           = 10;
   localparam int CODE_W          = 2;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CFG_W-1:0]   GRID_SIDE_RESET = 8'd128;
   localparam logic [COUNT_W:0]   PATH_MOD        = 31'd1000000007;
   localparam logic [SUM_W:0]     SUM_MAX         = 11'd1023;

   // register index, taken from the word address
   localparam logic               REG_GRID_SIDE   = 1'b0;

   // one column entry of the row above
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   sum;
      logic [CODE_W-1:0]  code;
      logic               reach;
   } line_entry_type;

   localparam int LINE_W = $bits(line_entry_type);

endpackage
`default_nettype wire

[design/gpcms_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module gpcms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[design/grid_path_count_max_sum.sv]
// top level: streaming grid path counter with best path sum
// flow: an accepted item is registered in the input stage and computed there; the
//   result of a grid's last cell is then registered; rsp_stall can hold that cell back
// throughput: else one cell per cycle, set by the left-neighbour modular add and max
// reset: synchronous, active high; grid_side returns to 128 and the grid restarts at the
//   top-left cell; the column line ram is not cleared, every entry is written before use
`default_nettype none
module grid_path_count_max_sum
   import gpcms_pkg::*;
#(
   parameter int MAX_SIDE = DEF_MAX_SIDE
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input item channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [CODE_W-1:0]     req_cell_code,
   // result item channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [COUNT_W-1:0]    rsp_path_count,
   output logic      [SUM_W-1:0]      rsp_best_sum,
   output logic                       rsp_reachable,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   // column index width for the line ram, position counter width wide enough for a side
   localparam int ADDR_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SIDE_NW = $clog2(MAX_SIDE + 1);
   localparam int POS_W   = (SIDE_NW > CFG_W) ? SIDE_NW : CFG_W;
   localparam logic [POS_W-1:0] MAX_SIDE_P = POS_W'(MAX_SIDE);

   // ---------------------------------------------------------------
   // configuration register
   // ---------------------------------------------------------------
   logic [CFG_W-1:0] grid_side_ff;
   logic             csr_write;
   logic             side_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign side_write = csr_write && (csr_paddr[2] == REG_GRID_SIDE);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_GRID_SIDE) begin
         csr_prdata = CSR_DATA_W'(grid_side_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff <= GRID_SIDE_RESET;
      end else if (side_write) begin
         grid_side_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   // side actually used: zero counts as one, clamp at the line depth
   logic [POS_W-1:0] side_raw;
   logic [POS_W-1:0] side_used;

   assign side_raw = POS_W'(grid_side_ff);

   always_comb begin
      if (side_raw == '0) begin
         side_used = POS_W'(1);
      end else if (side_raw > MAX_SIDE_P) begin
         side_used = MAX_SIDE_P;
      end else begin
         side_used = side_raw;
      end
   end

   // ---------------------------------------------------------------
   // position of the next item to be accepted
   // ---------------------------------------------------------------
   logic [POS_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [POS_W:0]   col_inc;
   logic [POS_W:0]   row_inc;
   logic             row_end;
   logic             grid_end;
   logic             req_accept;

   assign col_inc  = {1'b0, col_ff} + 1'b1;
   assign row_inc  = {1'b0, row_ff} + 1'b1;
   assign row_end  = (col_inc >= {1'b0, side_used});
   assign grid_end = row_end && (row_inc >= {1'b0, side_used});

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (side_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         col_in = row_end ? '0 : col_inc[POS_W-1:0];
         if (row_end) begin
            row_in = grid_end ? '0 : row_inc[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------
   // input register stage; the line ram read runs alongside it
   // ---------------------------------------------------------------
   logic              s1_valid_ff;
   logic [CODE_W-1:0] s1_code_ff;
   logic [ADDR_W-1:0] s1_col_ff;
   logic              s1_first_ff;   // top-left cell
   logic              s1_has_top_ff; // not in the first row
   logic              s1_has_left_ff;// not in the first column
   logic              s1_last_ff;    // bottom-right cell, gives a result
   logic              s1_advance;
   logic              out_free;

   assign out_free   = !rsp_valid || !rsp_stall;
   assign s1_advance = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_code_ff     <= req_cell_code;
         s1_col_ff      <= col_ff[ADDR_W-1:0];
         s1_first_ff    <= (row_ff == '0) && (col_ff == '0);
         s1_has_top_ff  <= (row_ff != '0);
         s1_has_left_ff <= (col_ff != '0);
         s1_last_ff     <= grid_end;
      end
   end

   // column line: the cell above, written back once the cell is done
   line_entry_type top_entry;
   line_entry_type new_entry;
   logic [LINE_W-1:0] top_bits;

   gpcms_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_SIDE)
   ) u_line (
      .clock   (clock),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (new_entry),
      .rd_en   (req_accept),
      .rd_addr (col_ff[ADDR_W-1:0]),
      .rd_data (top_bits)
   );

   assign top_entry = line_entry_type'(top_bits);

   // ---------------------------------------------------------------
   // left neighbour registers
   // ---------------------------------------------------------------
   logic [COUNT_W-1:0] left_count_ff;
   logic [SUM_W-1:0]   left_sum_ff;
   logic [CODE_W-1:0]  left_code_ff;
   logic               left_reach_ff;

   // ---------------------------------------------------------------
   // cell update: one modular add, one max, one saturating add
   // ---------------------------------------------------------------
   logic               top_ok;
   logic               left_ok;
   logic [COUNT_W:0]   cnt_sum;
   logic [COUNT_W-1:0] cnt_mod;
   logic [SUM_W-1:0]   best_in;
   logic [SUM_W:0]     best_add;
   logic               reach;

   assign top_ok  = s1_has_top_ff && top_entry.reach && top_entry.code[1];
   assign left_ok = s1_has_left_ff && left_reach_ff && left_code_ff[0];

   always_comb begin
      cnt_sum = (top_ok ? {1'b0, top_entry.count} : '0)
              + (left_ok ? {1'b0, left_count_ff} : '0);
      if (cnt_sum >= PATH_MOD) begin
         cnt_sum = cnt_sum - PATH_MOD;
      end
      best_in = '0;
      if (top_ok) begin
         best_in = top_entry.sum;
      end
      if (left_ok && (left_sum_ff > best_in)) begin
         best_in = left_sum_ff;
      end
      reach   = s1_first_ff || top_ok || left_ok;
      cnt_mod = s1_first_ff ? COUNT_W'(1) : cnt_sum[COUNT_W-1:0];
      if (s1_first_ff) begin
         best_in = '0;
      end
      best_add = {1'b0, best_in} + (SUM_W+1)'(s1_code_ff);
      if (best_add > SUM_MAX) begin
         best_add = SUM_MAX;
      end
      new_entry.reach = reach;
      new_entry.code  = s1_code_ff;
      new_entry.count = reach ? cnt_mod : '0;
      new_entry.sum   = reach ? best_add[SUM_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_count_ff <= '0;
         left_sum_ff   <= '0;
         left_code_ff  <= '0;
         left_reach_ff <= 1'b0;
      end else if (side_write) begin
         left_count_ff <= '0;
         left_sum_ff   <= '0;
         left_code_ff  <= '0;
         left_reach_ff <= 1'b0;
      end else if (s1_advance) begin
         left_count_ff <= new_entry.count;
         left_sum_ff   <= new_entry.sum;
         left_code_ff  <= new_entry.code;
         left_reach_ff <= new_entry.reach;
      end
   end

   // ---------------------------------------------------------------
   // result register; takes a new item while the old one is leaving
   // ---------------------------------------------------------------
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [SUM_W-1:0]   rsp_sum_ff;
   logic               rsp_reach_ff;
   logic               rsp_load;

   assign rsp_load = s1_advance && s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_count_ff <= new_entry.count;
         rsp_sum_ff   <= new_entry.sum;
         rsp_reach_ff <= new_entry.reach;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_count_ff;
   assign rsp_best_sum   = rsp_sum_ff;
   assign rsp_reachable  = rsp_reach_ff;

endmodule
`default_nettype wire
